// ===== hw/rtl/wfqs_pkg.sv =====
`timescale 1ns / 1ps
package wfqs_pkg;
    localparam int TIME_W = 48;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEL,
        ST_MEM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        accepted;
        logic        send_valid;
        logic [2:0]  send_queue;
        logic [31:0] send_item;
        logic [7:0]  nonempty_mask;
        logic        all_empty;
    } result_t;

    // 16-bit size times (S-w) fits in 24 bits; S <= 136 fits in 8.
    localparam int NUM_W = 24;
    localparam int DEN_W = 8;
endpackage

// ===== hw/rtl/wfqs_divider.sv =====
`timescale 1ns / 1ps
module wfqs_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [wfqs_pkg::NUM_W-1:0]      numer,
    input  logic [wfqs_pkg::DEN_W-1:0]      denom,
    output logic                            done,
    output logic [wfqs_pkg::NUM_W-1:0]      quot
);
    localparam int CNT_W = $clog2(wfqs_pkg::NUM_W + 1);

    logic [wfqs_pkg::NUM_W-1:0] q_reg, q_next;
    logic [wfqs_pkg::DEN_W:0]   r_reg, r_next;
    logic [wfqs_pkg::DEN_W-1:0] d_reg;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [wfqs_pkg::DEN_W:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[wfqs_pkg::DEN_W-1:0], q_reg[wfqs_pkg::NUM_W-1]};
        if (start) begin
            q_next = numer;
            r_next = '0;
            cnt_next = CNT_W'(wfqs_pkg::NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[wfqs_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[wfqs_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= denom;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ===== hw/rtl/wfqs_handle_ram.sv =====
`timescale 1ns / 1ps
module wfqs_handle_ram #(
    parameter int DEPTH = 512
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    input  logic [wfqs_pkg::HANDLE_W-1:0] wdata,
    output logic [wfqs_pkg::HANDLE_W-1:0] rdata
);
    logic [wfqs_pkg::HANDLE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/weighted_fair_queue_scheduler_core.sv =====
`timescale 1ns / 1ps
// Timing: an accepted enqueue waits on the 24-step bit-serial divider before its result is valid;
// a dequeue passes through the select, RAM read and output states, and a rejected enqueue goes
// straight to output.
// Throughput: one item at a time; the next item can be taken in the cycle after the result is accepted.
// Reset (aresetn low, synchronous): all queues empty, finish times zero, queue_count 3.
// The handle RAM is not cleared; entries are read only after being written.
module weighted_fair_queue_scheduler_core #(
    parameter int MAX_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[0], queue_index[3:1], item_handle[35:4], packet_size[51:36], now_ms[99:52],
    // token_mask[107:100]
    input  logic [111:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], send_valid[1], send_queue[4:2], send_item[36:5],
    // nonempty_mask[44:37], all_empty[45]
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(MAX_QUEUES * QUEUE_DEPTH);
    localparam int NW = $clog2(MAX_QUEUES + 1);

    wfqs_pkg::state_t state_reg, state_next;

    logic [3:0] qcount_reg;
    logic [wfqs_pkg::TIME_W-1:0] finish_reg [MAX_QUEUES];
    logic [PW-1:0] head_reg [MAX_QUEUES];
    logic [PW-1:0] tail_reg [MAX_QUEUES];
    logic [CW-1:0] fill_reg [MAX_QUEUES];

    logic        op_reg;
    logic [2:0]  qi_reg;
    logic [31:0] handle_reg;
    logic [15:0] size_reg;
    logic [47:0] now_reg;
    logic [7:0]  tok_reg;
    logic        found_reg;
    logic [QW-1:0] best_reg;
    wfqs_pkg::result_t res_reg;

    logic [NW-1:0] n_use;
    always_comb begin
        if (qcount_reg == 4'd0) n_use = NW'(1);
        else if (32'(qcount_reg) > MAX_QUEUES) n_use = NW'(MAX_QUEUES);
        else n_use = NW'(qcount_reg);
    end

    logic in_fire;
    assign s_tready = (state_reg == wfqs_pkg::ST_IDLE);
    assign in_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // enqueue qualification
    logic enq_ok;
    assign enq_ok = (32'(qi_reg) < 32'(n_use)) && (32'(qi_reg) < MAX_QUEUES) &&
                    (32'(fill_reg[QW'(qi_reg)]) < QUEUE_DEPTH);

    logic [wfqs_pkg::DEN_W-1:0] s_sum, w_val;
    logic [wfqs_pkg::NUM_W-1:0] numer;
    assign s_sum = wfqs_pkg::DEN_W'((32'(n_use) * (32'(n_use) + 1)) >> 1);
    assign w_val = wfqs_pkg::DEN_W'(32'(n_use) - 32'(qi_reg));
    assign numer = wfqs_pkg::NUM_W'(32'(size_reg) * 32'(s_sum - w_val));

    logic div_start, div_done;
    logic [wfqs_pkg::NUM_W-1:0] quot;
    assign div_start = (state_reg == wfqs_pkg::ST_DIV) && op_reg == wfqs_pkg::OP_ENQ;

    wfqs_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start && enq_ok),
        .numer(numer), .denom(s_sum), .done(div_done), .quot(quot)
    );

    // selection over queues in use
    logic          found_c;
    logic [QW-1:0] best_c;
    always_comb begin
        found_c = 1'b0;
        best_c = '0;
        for (int i = 0; i < MAX_QUEUES; i++) begin
            if (i < 8 && 32'(i) < 32'(n_use) && fill_reg[i] != '0 && tok_reg[i % 8]) begin
                if (!found_c || finish_reg[i] < finish_reg[best_c]) begin
                    found_c = 1'b1;
                    best_c = QW'(i);
                end
            end
        end
    end

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;
    always_comb begin
        ram_we = 1'b0;
        ram_addr = AW'(32'(best_reg) * QUEUE_DEPTH + 32'(head_reg[best_reg]));
        if (state_reg == wfqs_pkg::ST_DIV && op_reg == wfqs_pkg::OP_ENQ && enq_ok) begin
            ram_we = 1'b1;
            ram_addr = AW'(32'(qi_reg) * QUEUE_DEPTH + 32'(tail_reg[QW'(qi_reg)]));
        end
    end

    wfqs_handle_ram #(.DEPTH(MAX_QUEUES * QUEUE_DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(handle_reg), .rdata(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wfqs_pkg::ST_IDLE: if (in_fire) state_next = wfqs_pkg::ST_DIV;
            wfqs_pkg::ST_DIV: begin
                if (op_reg == wfqs_pkg::OP_DEQ) state_next = wfqs_pkg::ST_SEL;
                else if (!enq_ok) state_next = wfqs_pkg::ST_OUT;
                else state_next = wfqs_pkg::ST_SEL;
            end
            wfqs_pkg::ST_SEL: begin
                if (op_reg == wfqs_pkg::OP_DEQ) state_next = wfqs_pkg::ST_MEM;
                else if (div_done) state_next = wfqs_pkg::ST_OUT;
            end
            wfqs_pkg::ST_MEM: state_next = wfqs_pkg::ST_OUT;
            wfqs_pkg::ST_OUT: if (m_tready) state_next = wfqs_pkg::ST_IDLE;
            default: state_next = wfqs_pkg::ST_IDLE;
        endcase
    end

    logic [7:0] mask_c;
    logic       empty_c;
    always_comb begin
        mask_c = '0;
        empty_c = 1'b1;
        for (int i = 0; i < MAX_QUEUES; i++) begin
            if (fill_reg[i] != '0) begin
                if (i < 8) mask_c[i % 8] = 1'b1;
                if (32'(i) < 32'(n_use)) empty_c = 1'b0;
            end
        end
    end

    logic [wfqs_pkg::TIME_W-1:0] start_t;
    logic [wfqs_pkg::TIME_W:0]   fsum;
    assign start_t = (finish_reg[QW'(qi_reg)] > now_reg) ? finish_reg[QW'(qi_reg)] : now_reg;
    assign fsum = {1'b0, start_t} + (wfqs_pkg::TIME_W + 1)'(quot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wfqs_pkg::ST_IDLE;
            qcount_reg <= 4'd3;
            for (int i = 0; i < MAX_QUEUES; i++) begin
                finish_reg[i] <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) qcount_reg <= cfg_data;
            if (state_reg == wfqs_pkg::ST_DIV && op_reg == wfqs_pkg::OP_ENQ && enq_ok) begin
                tail_reg[QW'(qi_reg)] <= (32'(tail_reg[QW'(qi_reg)]) + 1 >= QUEUE_DEPTH)
                    ? '0 : tail_reg[QW'(qi_reg)] + 1'b1;
                fill_reg[QW'(qi_reg)] <= fill_reg[QW'(qi_reg)] + 1'b1;
            end
            if (state_reg == wfqs_pkg::ST_SEL && op_reg == wfqs_pkg::OP_ENQ && div_done)
                finish_reg[QW'(qi_reg)] <= fsum[wfqs_pkg::TIME_W] ? wfqs_pkg::TIME_MAX
                                                               : fsum[wfqs_pkg::TIME_W-1:0];
            if (state_reg == wfqs_pkg::ST_SEL && op_reg == wfqs_pkg::OP_DEQ && found_reg) begin
                head_reg[best_reg] <= (32'(head_reg[best_reg]) + 1 >= QUEUE_DEPTH)
                    ? '0 : head_reg[best_reg] + 1'b1;
                fill_reg[best_reg] <= fill_reg[best_reg] - 1'b1;
            end
        end
        if (in_fire) begin
            op_reg <= s_tdata[0];
            qi_reg <= s_tdata[3:1];
            handle_reg <= s_tdata[35:4];
            size_reg <= s_tdata[51:36];
            now_reg <= s_tdata[99:52];
            tok_reg <= s_tdata[107:100];
        end
        if (state_reg == wfqs_pkg::ST_DIV) begin
            found_reg <= found_c;
            best_reg <= best_c;
        end
        if (state_reg == wfqs_pkg::ST_MEM ||
            (state_reg == wfqs_pkg::ST_DIV && op_reg == wfqs_pkg::OP_ENQ && !enq_ok) ||
            (state_reg == wfqs_pkg::ST_SEL && op_reg == wfqs_pkg::OP_ENQ && div_done)) begin
            res_reg.accepted <= (op_reg == wfqs_pkg::OP_ENQ) &&
                                (state_reg == wfqs_pkg::ST_SEL);
            res_reg.send_valid <= (op_reg == wfqs_pkg::OP_DEQ) && found_reg;
            res_reg.send_queue <= ((op_reg == wfqs_pkg::OP_DEQ) && found_reg) ? 3'(best_reg) : '0;
            res_reg.send_item <= ((op_reg == wfqs_pkg::OP_DEQ) && found_reg) ? ram_rdata : '0;
            res_reg.nonempty_mask <= mask_c;
            res_reg.all_empty <= empty_c;
        end
    end

    assign m_tvalid = (state_reg == wfqs_pkg::ST_OUT);
    assign m_tdata = {2'b0, res_reg.all_empty, res_reg.nonempty_mask, res_reg.send_item,
                      res_reg.send_queue, res_reg.send_valid, res_reg.accepted};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while busy");
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1])) else $error("both enqueue and send");
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    localparam int NQ    = 8;
    localparam int DEPTH = 64;
    localparam int TW    = wfqs_pkg::TIME_W;

    class wfq_scoreboard;
        logic [3:0]          queue_count;
        logic [TW-1:0]       finish[NQ];
        logic [31:0]         handles[NQ][DEPTH];
        int                  head[NQ];
        int                  tail[NQ];
        int                  fill[NQ];
        wfqs_pkg::result_t   expected_results[$];
        int                  errors;

        function new();
            queue_count = 4'd3;
            errors = 0;
            for (int i = 0; i < NQ; i++) begin
                finish[i] = '0;
                head[i] = 0;
                tail[i] = 0;
                fill[i] = 0;
            end
        endfunction

        function int active_queues();
            if (queue_count == 0) return 1;
            if (queue_count > NQ) return NQ;
            return queue_count;
        endfunction

        function int depth_of(int q);
            return fill[q];
        endfunction

        // compute the result of one accepted item and advance queue state
        function void note_item(logic op, logic [2:0] qi, logic [31:0] handle,
                                logic [15:0] size, logic [TW-1:0] now,
                                logic [7:0] tokens);
            int          n;
            int          best;
            bit          found;
            longint unsigned s, w, inc, start, f;
            wfqs_pkg::result_t r;
            n = active_queues();
            r = '0;
            found = 0;
            best = 0;
            if (op == wfqs_pkg::OP_ENQ) begin
                if (qi < n && fill[qi] < DEPTH) begin
                    s = n * (n + 1) / 2;
                    w = n - qi;
                    inc = size * (s - w) / s;
                    start = (finish[qi] > now) ? finish[qi] : now;
                    f = start + inc;
                    if (f > wfqs_pkg::TIME_MAX) f = wfqs_pkg::TIME_MAX;
                    handles[qi][tail[qi]] = handle;
                    tail[qi] = (tail[qi] + 1) % DEPTH;
                    fill[qi]++;
                    finish[qi] = f[TW-1:0];
                    r.accepted = 1'b1;
                end
            end else begin
                for (int i = 0; i < n && i < 8; i++) begin
                    if (fill[i] != 0 && tokens[i] &&
                        (!found || finish[i] < finish[best])) begin
                        best = i;
                        found = 1;
                    end
                end
                if (found) begin
                    r.send_item = handles[best][head[best]];
                    head[best] = (head[best] + 1) % DEPTH;
                    fill[best]--;
                    r.send_valid = 1'b1;
                    r.send_queue = best[2:0];
                end
            end
            r.all_empty = 1'b1;
            for (int i = 0; i < NQ; i++) begin
                if (fill[i] != 0) begin
                    r.nonempty_mask[i] = 1'b1;
                    if (i < n) r.all_empty = 1'b0;
                end
            end
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_result(logic [47:0] bits);
            wfqs_pkg::result_t e;
            if (expected_results.size() == 0) begin
                $error("result without pending item: %h", bits);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (bits[0] !== e.accepted) begin
                $error("accepted exp %0d got %0d", e.accepted, bits[0]);
                errors++;
            end
            if (bits[1] !== e.send_valid) begin
                $error("send_valid exp %0d got %0d", e.send_valid, bits[1]);
                errors++;
            end
            if (bits[4:2] !== e.send_queue) begin
                $error("send_queue exp %0d got %0d", e.send_queue, bits[4:2]);
                errors++;
            end
            if (bits[36:5] !== e.send_item) begin
                $error("send_item exp %h got %h", e.send_item, bits[36:5]);
                errors++;
            end
            if (bits[44:37] !== e.nonempty_mask) begin
                $error("nonempty_mask exp %b got %b", e.nonempty_mask, bits[44:37]);
                errors++;
            end
            if (bits[45] !== e.all_empty) begin
                $error("all_empty exp %0d got %0d", e.all_empty, bits[45]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_data;

    wfq_scoreboard sb;
    bit            quiet;

    weighted_fair_queue_scheduler_core uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("weighted_fair_queue_scheduler_core verification failed");
        $finish;
    end

    function int draw_gap();
        if (quiet) return 0;
        return $urandom_range(0, 13);
    endfunction

    task automatic send_item(logic op, logic [2:0] qi, logic [31:0] handle,
                             logic [15:0] size, logic [TW-1:0] now,
                             logic [7:0] tokens = 8'hFF);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, tokens, now, size, handle, qi, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, qi, handle, size, now, tokens);
    endtask

    task automatic write_queue_count(logic [3:0] value);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.queue_count = value;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function logic [TW-1:0] draw_time();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return wfqs_pkg::TIME_MAX;
            2: return wfqs_pkg::TIME_MAX - TW'($urandom_range(0, 70000));
            3: return TW'($urandom_range(0, 1000));
            default: return TW'({$urandom, $urandom});
        endcase
    endfunction

    function logic [15:0] draw_size();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [7:0] draw_tokens();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return 8'hFF;
    endfunction

    // results side with random stalls
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        logic [3:0] settings[7];
        int         n;
        int         per_phase;
        logic       op;
        logic [2:0] qi;
        sb = new();
        quiet = 0;
        settings = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd3};
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset count of three queues
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        send_item(wfqs_pkg::OP_ENQ, 3'd0, 32'hFFFFFFFF, 16'hFFFF, wfqs_pkg::TIME_MAX);
        send_item(wfqs_pkg::OP_ENQ, 3'd1, 32'h00000000, 16'd0, '0);
        send_item(wfqs_pkg::OP_ENQ, 3'd2, 32'hA5A5A5A5, 16'hFFFF, '0);
        send_item(wfqs_pkg::OP_ENQ, 3'd3, 32'h12345678, 16'd100, 48'd5);
        send_item(wfqs_pkg::OP_ENQ, 3'd7, 32'h87654321, 16'd100, 48'd5);
        send_item(wfqs_pkg::OP_ENQ, 3'd1, 32'h5A5A5A5A, 16'hFFFF, wfqs_pkg::TIME_MAX - 1);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0, 8'h04);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0, 8'h00);
        send_item(wfqs_pkg::OP_DEQ, 3'd7, 32'hFFFFFFFF, 16'hFFFF, wfqs_pkg::TIME_MAX);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        drain();
        // shrink to one queue: queues left out keep contents
        write_queue_count(4'd1);
        send_item(wfqs_pkg::OP_ENQ, 3'd1, 32'h1, 16'd1, 48'd1);
        send_item(wfqs_pkg::OP_ENQ, 3'd0, 32'h2, 16'd1, 48'd1);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        drain();
        write_queue_count(4'd3);
        send_item(wfqs_pkg::OP_ENQ, 3'd2, 32'h3, 16'd7, 48'd0);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        send_item(wfqs_pkg::OP_DEQ, 3'd0, 32'h0, 16'd0, '0);
        drain();

        per_phase = 135;
        foreach (settings[p]) begin
            write_queue_count(settings[p]);
            n = sb.active_queues();
            quiet = (p % 3 == 1);
            for (int k = 0; k < per_phase; k++) begin
                // early part of a phase fills queues, sometimes to the brim
                op = ($urandom_range(0, 99) < ((k < per_phase / 2) ? 35 : 60))
                     ? wfqs_pkg::OP_DEQ : wfqs_pkg::OP_ENQ;
                if ($urandom_range(0, 9) == 0) qi = 3'($urandom);
                else qi = 3'($urandom_range(0, n - 1));
                if (n == 1 && k < 90)
                    op = (k % 10 == 9) ? wfqs_pkg::OP_DEQ : wfqs_pkg::OP_ENQ;
                send_item(op, qi, $urandom, draw_size(), draw_time(), draw_tokens());
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("weighted_fair_queue_scheduler_core verification clean");
        end else begin
            if (sb.expected_results.size() != 0)
                $error("%0d results never arrived", sb.expected_results.size());
            $display("weighted_fair_queue_scheduler_core verification failed");
        end
        $finish;
    end
endmodule
